// File: src/assert_macros.svh
// Assertion macros shared by the quantizer RTL.
// Included by every module that carries concurrent checks; needs a clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check on every rising edge outside reset.
`define PIQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("piq assertion failed");
// Check on every rising edge, reset included.
`define PIQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("piq assertion failed");
`else
`define PIQ_ASSERT(label, prop)
`define PIQ_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: src/piq_pkg.sv
// Package for the palette index quantizer: payload structs, codes and constants.
// Used by piq_regs, piq_raster, piq_cell and palette_index_quantizer.
`default_nettype none
package piq_pkg;

  localparam int PIQ_MAX_WIDTH       = 512;
  localparam int PIQ_MAX_HEIGHT      = 512;
  localparam int PIQ_PALETTE_ENTRIES = 16;

  localparam int PIQ_CFG_W   = 10;  // width of the dimension registers
  localparam int PIQ_CHAN_W  = 8;   // one color component
  localparam int PIQ_ENTRY_W = 4;   // entry number and palette index on the ports
  localparam int PIQ_ADDR_W  = 18;  // destination address
  localparam int PIQ_DIST_W  = 18;  // squared distance, three 16-bit squares
  localparam int PIQ_IDX_W   = 8;   // internal index, enough for 256 entries
  localparam int PIQ_DATA_W  = 32;
  localparam int PIQ_PADDR_W = 3;

  localparam logic [PIQ_CFG_W-1:0] PIQ_DIM_RESET = 10'd16;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_PIXEL = 1'b1
  } piq_action_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } piq_reg_t;

  typedef struct packed {
    logic                   action;
    logic [PIQ_ENTRY_W-1:0] entry_number;
    logic [PIQ_CHAN_W-1:0]  red;
    logic [PIQ_CHAN_W-1:0]  green;
    logic [PIQ_CHAN_W-1:0]  blue;
  } piq_req_t;

  typedef struct packed {
    logic [PIQ_ENTRY_W-1:0] palette_index;
    logic [PIQ_ADDR_W-1:0]  dest_address;
    logic                   frame_end;
  } piq_result_t;

  typedef struct packed {
    logic [PIQ_CFG_W-1:0] image_width;
    logic [PIQ_CFG_W-1:0] image_height;
  } piq_cfg_t;

  // One slot of the processing line: a palette write or a pixel with its running best.
  typedef struct packed {
    logic                   valid;
    logic                   pixel;
    logic [PIQ_ENTRY_W-1:0] entry_number;
    logic [PIQ_CHAN_W-1:0]  red;
    logic [PIQ_CHAN_W-1:0]  green;
    logic [PIQ_CHAN_W-1:0]  blue;
    logic [PIQ_ADDR_W-1:0]  dest_address;
    logic                   frame_end;
    logic [PIQ_IDX_W-1:0]   best_index;
    logic [PIQ_DIST_W-1:0]  best_dist;
  } piq_item_t;

endpackage
`default_nettype wire

// File: src/piq_regs.sv
// Configuration registers of the quantizer behind an APB-style port.
// Depends on piq_pkg.
`default_nettype none
module piq_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [piq_pkg::PIQ_PADDR_W-1:0] paddr,
  input  wire logic [piq_pkg::PIQ_DATA_W-1:0]  pwdata,
  output logic      [piq_pkg::PIQ_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output piq_pkg::piq_cfg_t                    cfg
);
  import piq_pkg::*;

  logic     wr_en;
  piq_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = piq_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= PIQ_DIM_RESET;
      cfg.image_height <= PIQ_DIM_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[PIQ_CFG_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[PIQ_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = PIQ_DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = PIQ_DATA_W'(cfg.image_height);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/piq_raster.sv
// Front of the processing line: raster position counters and the flipped destination address.
// Depends on piq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module piq_raster #(
  parameter int MAX_WIDTH  = piq_pkg::PIQ_MAX_WIDTH,
  parameter int MAX_HEIGHT = piq_pkg::PIQ_MAX_HEIGHT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               req_valid,
  input  piq_pkg::piq_req_t       req,
  input  piq_pkg::piq_cfg_t       cfg,
  output piq_pkg::piq_item_t      item
);
  import piq_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int PROD_W = ROW_W + W_W;

  logic [COL_W-1:0]  col_cnt, col_cnt_next;
  logic [ROW_W-1:0]  row_cnt, row_cnt_next;
  logic [W_W-1:0]    w;
  logic [H_W-1:0]    h;
  logic              wrap;
  logic [H_W-1:0]    row_step;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [W_W-1:0]    col_inc;
  logic [H_W-1:0]    row_inc;
  logic              last;
  logic [ROW_W-1:0]  flip;
  logic              pix_acc;

  piq_item_t         r1;
  logic [ROW_W-1:0]  r1_flip;
  logic [COL_W-1:0]  r1_col;
  logic [W_W-1:0]    r1_w;
  logic [PROD_W-1:0] addr_sum;
  piq_item_t         item_next;

  // Out-of-range dimensions are pulled into 1..MAX.
  always_comb begin
    if (cfg.image_width == '0) begin
      w = W_W'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w = W_W'(MAX_WIDTH);
    end else begin
      w = W_W'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h = H_W'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h = H_W'(MAX_HEIGHT);
    end else begin
      h = H_W'(cfg.image_height);
    end
  end

  // Counters left beyond the frame by a register change fold back into it here.
  always_comb begin
    wrap     = W_W'(col_cnt) >= w;
    col      = wrap ? '0 : col_cnt;
    row_step = wrap ? H_W'(row_cnt) + H_W'(1) : H_W'(row_cnt);
    row      = (row_step >= h) ? '0 : row_step[ROW_W-1:0];
    last     = (W_W'(col) == w - W_W'(1)) && (H_W'(row) == h - H_W'(1));
    flip     = ROW_W'(h - H_W'(1) - H_W'(row));
    col_inc  = W_W'(col) + W_W'(1);
    row_inc  = H_W'(row) + H_W'(1);
    if (col_inc < w) begin
      col_cnt_next = COL_W'(col_inc);
      row_cnt_next = row;
    end else if (row_inc < h) begin
      col_cnt_next = '0;
      row_cnt_next = ROW_W'(row_inc);
    end else begin
      col_cnt_next = '0;
      row_cnt_next = '0;
    end
  end

  assign pix_acc = adv && req_valid && (req.action == ACT_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (pix_acc) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1.valid <= 1'b0;
    end else if (adv) begin
      r1.valid        <= req_valid;
      r1.pixel        <= (req.action == ACT_PIXEL);
      r1.entry_number <= req.entry_number;
      r1.red          <= req.red;
      r1.green        <= req.green;
      r1.blue         <= req.blue;
      r1.dest_address <= '0;
      r1.frame_end    <= last;
      r1.best_index   <= '0;
      r1.best_dist    <= '0;
      r1_flip         <= flip;
      r1_col          <= col;
      r1_w            <= w;
    end
  end

  assign addr_sum = PROD_W'(r1_flip) * PROD_W'(r1_w) + PROD_W'(r1_col);

  always_comb begin
    item_next              = r1;
    item_next.dest_address = PIQ_ADDR_W'(addr_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (adv) begin
      item <= item_next;
    end
  end

  `PIQ_ASSERT(a_frame_restart, pix_acc && last |=> col_cnt == '0 && row_cnt == '0)
  `PIQ_ASSERT(a_col_in_row, r1.valid && r1.pixel |-> W_W'(r1_col) < r1_w)

endmodule
`default_nettype wire

// File: src/piq_cell.sv
// One palette cell: holds one entry, scores the passing pixel against it, keeps the best so far.
// Depends on piq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module piq_cell #(
  parameter int CELL_INDEX = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  piq_pkg::piq_item_t din,
  output piq_pkg::piq_item_t dout
);
  import piq_pkg::*;

  localparam logic             FIRST   = (CELL_INDEX == 1);
  localparam [PIQ_IDX_W-1:0]   MY_IDX  = PIQ_IDX_W'(CELL_INDEX);

  logic [PIQ_CHAN_W-1:0]   ent_r, ent_g, ent_b;
  logic [PIQ_CHAN_W-1:0]   dr, dg, db;
  piq_item_t               a;
  logic [2*PIQ_CHAN_W-1:0] sq_r, sq_g, sq_b;
  logic [PIQ_DIST_W-1:0]   score;
  logic                    take;
  logic                    wr_hit;
  piq_item_t               dout_next;

  // A write updates the entry at the same place where pixels read it, so order holds.
  assign wr_hit = adv && din.valid && !din.pixel &&
                  (PIQ_IDX_W'(din.entry_number) == MY_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_r <= '0;
      ent_g <= '0;
      ent_b <= '0;
    end else if (wr_hit) begin
      ent_r <= din.red;
      ent_g <= din.green;
      ent_b <= din.blue;
    end
  end

  assign dr = (din.red   >= ent_r) ? din.red   - ent_r : ent_r - din.red;
  assign dg = (din.green >= ent_g) ? din.green - ent_g : ent_g - din.green;
  assign db = (din.blue  >= ent_b) ? din.blue  - ent_b : ent_b - din.blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      a.valid <= 1'b0;
    end else if (adv) begin
      a    <= din;
      sq_r <= (2*PIQ_CHAN_W)'(dr) * (2*PIQ_CHAN_W)'(dr);
      sq_g <= (2*PIQ_CHAN_W)'(dg) * (2*PIQ_CHAN_W)'(dg);
      sq_b <= (2*PIQ_CHAN_W)'(db) * (2*PIQ_CHAN_W)'(db);
    end
  end

  // Strictly less keeps the lower index on a tie.
  assign score = PIQ_DIST_W'(sq_r) + PIQ_DIST_W'(sq_g) + PIQ_DIST_W'(sq_b);
  assign take  = a.pixel && (FIRST || (score < a.best_dist));

  always_comb begin
    dout_next = a;
    if (take) begin
      dout_next.best_index = MY_IDX;
      dout_next.best_dist  = score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout <= dout_next;
    end
  end

  `PIQ_ASSERT(a_index_range, dout.valid && dout.pixel |-> dout.best_index >= PIQ_IDX_W'(1) && dout.best_index <= MY_IDX)
  `PIQ_ASSERT(a_dist_monotone, !FIRST && adv && a.valid && a.pixel |=> dout.best_dist <= $past(a.best_dist))

endmodule
`default_nettype wire

// File: src/palette_index_quantizer.sv
// Palette index quantizer: requests enter at one per clock while results are taken. A pixel
// passes two register stages of raster counting and address multiply, then a line of palette
// cells, one per entry from 1 upward, each two register stages deep (squares, then sum and
// compare). Palette writes travel the same line, so a pixel sees exactly the writes requested
// before it. While a result waits to be taken the whole line holds and no request is accepted.
// Reset clears the palette at once; no clearing pass is needed. Depends on piq_pkg, piq_regs,
// piq_raster, piq_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module palette_index_quantizer #(
  parameter int MAX_WIDTH       = piq_pkg::PIQ_MAX_WIDTH,
  parameter int MAX_HEIGHT      = piq_pkg::PIQ_MAX_HEIGHT,
  parameter int PALETTE_ENTRIES = piq_pkg::PIQ_PALETTE_ENTRIES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  piq_pkg::piq_req_t                    req,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output piq_pkg::piq_result_t                 result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [piq_pkg::PIQ_PADDR_W-1:0] paddr,
  input  wire logic [piq_pkg::PIQ_DATA_W-1:0]  pwdata,
  output logic      [piq_pkg::PIQ_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import piq_pkg::*;

  localparam int NCELL = PALETTE_ENTRIES - 1;

  piq_cfg_t  cfg;
  logic      adv;
  piq_item_t link [0:NCELL];

  assign adv       = !result_valid || result_ready;
  assign req_ready = adv;

  piq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  piq_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req),
    .cfg       (cfg),
    .item      (link[0])
  );

  for (genvar k = 1; k <= NCELL; k++) begin : g_cell
    piq_cell #(
      .CELL_INDEX (k)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (link[k-1]),
      .dout (link[k])
    );
  end

  // Writes drop out at the end of the line; only pixels make results.
  assign result_valid         = link[NCELL].valid && link[NCELL].pixel;
  assign result.palette_index = link[NCELL].best_index[PIQ_ENTRY_W-1:0];
  assign result.dest_address  = link[NCELL].dest_address;
  assign result.frame_end     = link[NCELL].frame_end;

  `PIQ_ASSERT(a_no_entry_zero, result_valid && (PALETTE_ENTRIES <= 16) |-> result.palette_index != '0)

endmodule
`default_nettype wire
